// File: rtl/core/mfx_pkg.sv
// Package: shared types and constants for the Manchester frame transmitter.
`timescale 1ns / 1ps

package mfx_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSTAMBLE = 2'd1;

  // Register limits and reset values
  localparam logic [3:0] PREAMBLE_MAX    = 4'd12;
  localparam logic [3:0] POSTAMBLE_MAX   = 4'd11;
  localparam logic [3:0] PREAMBLE_RESET  = 4'd10;
  localparam logic [3:0] POSTAMBLE_RESET = 4'd4;

  // Index of the last data bit in a byte; bits are sent LSB first
  localparam logic [3:0] LAST_DATA_BIT = 4'd7;

  // One classified byte, ready for the serializer
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] pre;   // preamble one bits, zero when not frame start
    logic [3:0] post;  // postamble zero bits, valid when closing
    logic       close; // frame end: postamble plus trailing low half-bit
  } job_t;

endpackage

// File: rtl/core/mfx_front.sv
// Front end: configuration registers and classification of incoming bytes.
`timescale 1ns / 1ps

module mfx_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mfx_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mfx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_first_byte,
  input  logic                            in_last_byte,
  output mfx_pkg::job_t                   job
);

  logic [3:0] preamble_r;
  logic [3:0] postamble_r;
  logic [3:0] pre_sat;
  logic [3:0] post_sat;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r  <= mfx_pkg::PREAMBLE_RESET;
      postamble_r <= mfx_pkg::POSTAMBLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mfx_pkg::CFG_PREAMBLE:  preamble_r  <= cfg_wdata;
        mfx_pkg::CFG_POSTAMBLE: postamble_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp counts to their legal range
  assign pre_sat  = (preamble_r > mfx_pkg::PREAMBLE_MAX) ? mfx_pkg::PREAMBLE_MAX : preamble_r;
  assign post_sat = (postamble_r > mfx_pkg::POSTAMBLE_MAX) ? mfx_pkg::POSTAMBLE_MAX
                                                           : postamble_r;

  // Build the job descriptor
  always_comb begin
    job.data  = in_data_byte;
    job.pre   = in_first_byte ? pre_sat : 4'd0;
    job.post  = in_last_byte ? post_sat : 4'd0;
    job.close = in_last_byte;
  end

endmodule

// File: rtl/core/mfx_job_fifo.sv
// Short job queue between front end and serializer.
`timescale 1ns / 1ps

module mfx_job_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  mfx_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output mfx_pkg::job_t rd_job,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mfx_pkg::job_t   mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign full   = (cnt_r == FULL_CNT);
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Fill count never exceeds depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("job queue count overflow");

  // A read while holding one entry and no write leaves the queue empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr && cnt_r == CW'(1)) |=> empty) else $error("job queue drain");

  // A write to an empty queue makes it non-empty
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && empty) |=> !empty) else $error("job queue fill");

endmodule

// File: rtl/core/mfx_serializer.sv
// Back end: Manchester serializer with output register.
`timescale 1ns / 1ps

module mfx_serializer (
  input  logic          clk,
  input  logic          rst_n,
  input  mfx_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic          out_line_level,
  output logic          out_run_end
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PRE  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_POST = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;

  logic [2:0]    phase_r, phase_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          half_r, half_nxt;
  mfx_pkg::job_t job_r;
  logic          out_valid_r, out_valid_nxt;
  logic          level_r;
  logic          run_end_r;
  logic          room;
  logic          emit;
  logic          level;
  logic          run_end;

  // Output register has room when empty or being drained
  assign room  = !out_valid_r || out_pop;
  assign emit  = (phase_r != PH_IDLE) && room;
  assign q_pop = (phase_r == PH_IDLE) && !q_empty;

  // Half-bit level for the current position
  always_comb begin
    level   = 1'b0;
    run_end = 1'b0;
    unique case (phase_r)
      PH_PRE:  level = !half_r;
      PH_DATA: begin
        level   = job_r.data[cnt_r[2:0]] ^ half_r;
        run_end = half_r && (cnt_r == mfx_pkg::LAST_DATA_BIT) && !job_r.close;
      end
      PH_POST: level = half_r;
      PH_TAIL: run_end = 1'b1;
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    half_nxt  = half_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (!q_empty) begin
          phase_nxt = (q_job.pre != 4'd0) ? PH_PRE : PH_DATA;
          cnt_nxt   = 4'd0;
          half_nxt  = 1'b0;
        end
      end
      PH_PRE: begin
        if (emit) begin
          half_nxt = !half_r;
          if (half_r) begin
            if (cnt_r == job_r.pre - 4'd1) begin
              phase_nxt = PH_DATA;
              cnt_nxt   = 4'd0;
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
        end
      end
      PH_DATA: begin
        if (emit) begin
          half_nxt = !half_r;
          if (half_r) begin
            if (cnt_r == mfx_pkg::LAST_DATA_BIT) begin
              cnt_nxt = 4'd0;
              if (!job_r.close) begin
                phase_nxt = PH_IDLE;
              end else if (job_r.post != 4'd0) begin
                phase_nxt = PH_POST;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
        end
      end
      PH_POST: begin
        if (emit) begin
          half_nxt = !half_r;
          if (half_r) begin
            if (cnt_r == job_r.post - 4'd1) begin
              phase_nxt = PH_TAIL;
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
        end
      end
      PH_TAIL: begin
        if (emit) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Output register valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= 4'd0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      level_r   <= level;
      run_end_r <= run_end;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_line_level = level_r;
  assign out_run_end    = run_end_r;

  // Preamble phase only with a nonzero preamble count
  a_pre_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PRE) |-> (job_r.pre != 4'd0)) else $error("preamble without count");

  // Postamble and tail only for a frame-closing byte
  a_post_close: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_POST || phase_r == PH_TAIL) |-> job_r.close)
    else $error("postamble on non-closing byte");

  // Bit index stays within a byte during data
  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r <= mfx_pkg::LAST_DATA_BIT)) else $error("data index range");

  // The trailing half-bit ends the run and returns to idle
  a_tail_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && phase_r == PH_TAIL) |=> (phase_r == PH_IDLE && out_run_end))
    else $error("tail did not close run");

endmodule

// File: rtl/core/manchester_frame_transmitter_top.sv
// Path: bytes enter the job queue, which takes pushes while the serializer is busy, then
//   its job register; each half-bit level is registered in the output register.
// Per byte: job load, 16 data half-bits, two per preamble and postamble bit, and a
//   trailing low half-bit; one level per cycle while the output register has room.
// Reset (synchronous, rst_n low): queues empty, preamble count 10, postamble count 4.
`timescale 1ns / 1ps

module manchester_frame_transmitter_top #(
  parameter int JOB_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mfx_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mfx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_first_byte,
  input  logic                            in_last_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_line_level,
  output logic                            out_run_end
);

  mfx_pkg::job_t new_job;
  mfx_pkg::job_t q_job;
  logic          q_empty;
  logic          q_pop;

  // Classify incoming bytes
  mfx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .job           (new_job)
  );

  // Decoupling queue
  mfx_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_push),
    .wr_job (new_job),
    .full   (in_full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  // Serialize half-bit levels
  mfx_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (q_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_line_level (out_line_level),
    .out_run_end    (out_run_end)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the Manchester frame transmitter top level.
`timescale 1ns / 1ps

module tb_top;

  // Run control
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 43;
  localparam int REPORT_LIMIT = 10;

  // Configuration port types
  typedef logic [mfx_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [mfx_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // Indexes past the defined registers
  localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
  localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

  // One byte transaction toward the block
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } byte_item_t;

  // One expected half-bit level
  typedef struct packed {
    logic level;
    logic run_end;
  } half_bit_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_idx = '0;
  cfg_data_t  cfg_wdata = '0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_last_byte = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic       out_line_level;
  logic       out_run_end;

  // Stimulus and expectation stores
  byte_item_t pending_bytes[$];
  half_bit_t  expected_levels[$];

  // Shadow copy of the length registers
  logic [3:0] preamble_cnt = mfx_pkg::PREAMBLE_RESET;
  logic [3:0] postamble_cnt = mfx_pkg::POSTAMBLE_RESET;

  // Pacing knobs set per phase
  int unsigned send_idle_max = 5;
  int unsigned recv_idle_max = 5;
  logic        long_hold_req = 1'b0;

  // Bookkeeping
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_opened = 0;
  int unsigned levels_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;

  // Driver and monitor private state
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  logic        long_hold_done = 1'b0;
  logic        push_busy;
  logic        pop_next;
  byte_item_t  next_byte;
  half_bit_t   want;

  manchester_frame_transmitter_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_line_level(out_line_level),
    .out_run_end   (out_run_end)
  );

  // Clock
  always #5 clk = ~clk;

  // Expected line levels for one byte under the current register values
  task automatic predict_levels(input logic [7:0] data, input logic first,
                                input logic last);
    logic       lv[$];
    logic [3:0] pre_bits;
    logic [3:0] post_bits;
    half_bit_t  hb;
    pre_bits = (preamble_cnt > mfx_pkg::PREAMBLE_MAX) ? mfx_pkg::PREAMBLE_MAX
                                                      : preamble_cnt;
    post_bits = (postamble_cnt > mfx_pkg::POSTAMBLE_MAX) ? mfx_pkg::POSTAMBLE_MAX
                                                         : postamble_cnt;
    if (first) begin
      for (int i = 0; i < pre_bits; i++) begin
        lv.push_back(1'b1);
        lv.push_back(1'b0);
      end
    end
    // one is high-low, zero is low-high, LSB first
    for (int i = 0; i < 8; i++) begin
      lv.push_back(data[i]);
      lv.push_back(~data[i]);
    end
    if (last) begin
      for (int i = 0; i < post_bits; i++) begin
        lv.push_back(1'b0);
        lv.push_back(1'b1);
      end
      lv.push_back(1'b0);
    end
    foreach (lv[k]) begin
      hb.level = lv[k];
      hb.run_end = (k == lv.size() - 1);
      expected_levels.push_back(hb);
    end
  endtask

  task automatic note_failure(input string what, input logic exp_level,
                              input logic exp_end);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected level=%0b run_end=%0b, got level=%0b run_end=%0b",
               $realtime, what, exp_level, exp_end, out_line_level, out_run_end);
    end
  endtask

  // Driver: one byte transaction at a time, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
    end else begin
      push_busy = in_push;
      if (in_push && !in_full) begin
        predict_levels(in_data_byte, in_first_byte, in_last_byte);
        bytes_sent++;
        if (in_first_byte) frames_opened++;
        push_busy = 1'b0;
      end
      if (!push_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_byte = pending_bytes.pop_front();
          in_data_byte <= next_byte.data;
          in_first_byte <= next_byte.first;
          in_last_byte <= next_byte.last;
          in_push <= 1'b1;
          send_gap = $urandom_range(0, send_idle_max);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pop with random pauses, one long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      recv_gap = 0;
    end else begin
      pop_next = out_pop;
      if (out_pop && !out_empty) begin
        levels_checked++;
        if (expected_levels.size() == 0) begin
          note_failure("unexpected level", 1'bx, 1'bx);
        end else begin
          want = expected_levels.pop_front();
          if (want.level !== out_line_level || want.run_end !== out_run_end)
            note_failure("level mismatch", want.level, want.run_end);
        end
        pop_next = 1'b0;
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (!pop_next) begin
        if (recv_gap > 0) begin
          recv_gap--;
        end else begin
          pop_next = 1'b1;
          recv_gap = $urandom_range(0, recv_idle_max);
        end
      end
      out_pop <= pop_next;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d levels still expected",
               cycle_count, expected_levels.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Register write; the block is idle whenever this is called
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      mfx_pkg::CFG_PREAMBLE:  preamble_cnt = val;
      mfx_pkg::CFG_POSTAMBLE: postamble_cnt = val;
      default: ;  // unused indexes are ignored
    endcase
  endtask

  // Wait until every byte is accepted and every level has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_push || expected_levels.size() != 0);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic first,
                            input logic last);
    byte_item_t it;
    it.data = data;
    it.first = first;
    it.last = last;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_frame(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      queue_byte(8'($urandom_range(0, 255)), k == 0, k == len - 1);
  endtask

  // Phase sequencing
  initial begin
    int unsigned queued;
    int unsigned len;
    logic [3:0] pre_sel;
    logic [3:0] post_sel;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset lengths, data extremes, every flag combination
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hAA, 1'b0, 1'b0);
    queue_byte(8'h55, 1'b0, 1'b1);
    queue_byte(8'h01, 1'b1, 1'b1);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b1);
    queue_byte(8'hA5, 1'b1, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b1);
    wait_idle();

    // Unused indexes must not touch the lengths; then zero-length framing
    write_reg(CFG_SPARE_LO, 4'h0);
    write_reg(CFG_SPARE_HI, 4'hF);
    queue_byte(8'h3C, 1'b1, 1'b1);
    wait_idle();
    write_reg(mfx_pkg::CFG_PREAMBLE, 4'd0);
    write_reg(mfx_pkg::CFG_POSTAMBLE, 4'd0);
    queue_byte(8'hC3, 1'b1, 1'b1);
    queue_byte(8'h0F, 1'b1, 1'b0);
    queue_byte(8'hF0, 1'b0, 1'b1);
    wait_idle();

    // Out-of-range lengths saturate; longest possible runs
    write_reg(mfx_pkg::CFG_PREAMBLE, 4'd15);
    write_reg(mfx_pkg::CFG_POSTAMBLE, 4'd15);
    queue_byte(8'hF0, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b1, 1'b1);
    wait_idle();
    write_reg(mfx_pkg::CFG_PREAMBLE, 4'd13);
    write_reg(mfx_pkg::CFG_POSTAMBLE, 4'd12);
    queue_byte(8'h77, 1'b1, 1'b1);
    wait_idle();
    write_reg(mfx_pkg::CFG_PREAMBLE, mfx_pkg::PREAMBLE_MAX);
    write_reg(mfx_pkg::CFG_POSTAMBLE, mfx_pkg::POSTAMBLE_MAX);
    queue_byte(8'h88, 1'b1, 1'b1);
    wait_idle();

    // Random phases: mostly well-formed frames, some stray flag mixes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin pre_sel = 4'd0;  post_sel = 4'd0;  end
        1: begin pre_sel = 4'd12; post_sel = 4'd11; end
        2: begin pre_sel = 4'd15; post_sel = 4'd15; end
        3: begin pre_sel = 4'd1;  post_sel = 4'd0;  end
        4: begin
          pre_sel = mfx_pkg::PREAMBLE_RESET;
          post_sel = mfx_pkg::POSTAMBLE_RESET;
        end
        default: begin
          pre_sel = 4'($urandom_range(0, 15));
          post_sel = 4'($urandom_range(0, 15));
        end
      endcase
      write_reg(mfx_pkg::CFG_PREAMBLE, pre_sel);
      write_reg(mfx_pkg::CFG_POSTAMBLE, post_sel);
      if ($urandom_range(0, 1))
        write_reg(cfg_idx_t'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  cfg_data_t'($urandom_range(0, 15)));

      // no idling at all in some phases, full random pacing elsewhere
      send_idle_max = (p == 0 || p == 3) ? 0 : 5;
      recv_idle_max = (p == 0 || p == 3) ? 0 : 5;
      if (p == 2) long_hold_req = 1'b1;

      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 15) begin
          queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          queued++;
        end else begin
          len = $urandom_range(1, 5);
          queue_frame(len);
          queued += len;
        end
      end
      // sender holds off here until the block has fully drained
      wait_idle();
    end

    // Let any stray level show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_levels.size() != 0) begin
      fail_count++;
      $display("%0d expected levels never arrived", expected_levels.size());
    end

    $display("Sent %0d bytes (%0d frame starts) over %0d register writes,",
             bytes_sent, frames_opened, reg_writes);
    $display("checked %0d line levels including saturated lengths and a long output stall",
             levels_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
